[rtl/core/crkc_pkg.sv]
// types and constants shared by the key cache core and its submodules
`default_nettype none

package crkc_pkg;

  localparam int unsigned CTX_W       = 16;
  localparam int unsigned STM_W       = 32;
  localparam int unsigned SLOT_W      = 6;
  localparam int unsigned ENTRIES_DEF = 64;

  // one cache slot as it travels around the ring
  typedef struct packed {
    logic [CTX_W-1:0] ctx;
    logic [STM_W-1:0] stm;
    logic             used;
  } entry_t;

  // controller to ring: rotate enable and the entry fed into the last cell
  typedef struct packed {
    logic   shift;
    entry_t wrap;
  } ring_ctl_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              hit;
    logic              evicted;
    logic [CTX_W-1:0]  ev_ctx;
    logic [STM_W-1:0]  ev_stm;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_PLACE
  } state_e;

endpackage

`default_nettype wire

[rtl/core/crkc_cell.sv]
// one storage cell of the rotating slot ring
`default_nettype none

module crkc_cell
  import crkc_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   shift_i,
  input  wire entry_t entry_i,
  output entry_t      entry_o
);

  logic [CTX_W-1:0] ctx_q;
  logic [STM_W-1:0] stm_q;
  logic             used_q;

  // key payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      ctx_q <= entry_i.ctx;
      stm_q <= entry_i.stm;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
    end else if (shift_i) begin
      used_q <= entry_i.used;
    end
  end

  assign entry_o.ctx  = ctx_q;
  assign entry_o.stm  = stm_q;
  assign entry_o.used = used_q;

endmodule

`default_nettype wire

[rtl/core/crkc_ctrl.sv]
// request sequencer: search pass, fill or clock sweep, result register
`default_nettype none

module crkc_ctrl
  import crkc_pkg::*;
#(
  parameter int unsigned ENTRIES = ENTRIES_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  output logic                  busy_o,
  input  wire logic [CTX_W-1:0] ctx_i,
  input  wire logic [STM_W-1:0] stm_i,
  input  wire entry_t           head_i,
  output ring_ctl_t             ring_o,
  output logic                  done_o,
  output result_t               res_o
);

  localparam int unsigned IW = $clog2(ENTRIES);
  localparam int unsigned FW = $clog2(ENTRIES + 1);
  localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);
  localparam logic [FW-1:0] FULL = FW'(ENTRIES);

  state_e           state_q, state_d;
  logic [IW-1:0]    idx_q, idx_d;
  logic [IW-1:0]    cnt_q, cnt_d;
  logic [FW-1:0]    fill_q, fill_d;
  logic [IW-1:0]    hand_q, hand_d;
  logic             sweep_q, sweep_d;
  logic             hit_q, hit_d;
  logic [IW-1:0]    hit_idx_q, hit_idx_d;
  logic [CTX_W-1:0] ctx_q, ctx_d;
  logic [STM_W-1:0] stm_q, stm_d;
  logic             done_q, done_d;
  result_t          res_q, res_d;

  logic head_valid, match, full, sweep_on, place_now, search_last;

  assign head_valid  = FW'(idx_q) < fill_q;
  assign match       = head_valid && (head_i.ctx == ctx_q) && (head_i.stm == stm_q);
  assign full        = (fill_q == FULL);
  assign sweep_on    = sweep_q || (idx_q == hand_q);
  assign place_now   = (state_q == ST_PLACE) &&
                       ((!full && (FW'(idx_q) == fill_q)) ||
                        (full && sweep_on && !head_i.used));
  assign search_last = (state_q == ST_SEARCH) && (cnt_q == LAST);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) state_d = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (search_last) state_d = (hit_q || match) ? ST_IDLE : ST_PLACE;
      end
      ST_PLACE: begin
        if (place_now) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    ring_o.shift = (state_q != ST_IDLE);
    ring_o.wrap  = head_i;
    idx_d        = idx_q;
    cnt_d        = cnt_q;
    fill_d       = fill_q;
    hand_d       = hand_q;
    sweep_d      = sweep_q;
    hit_d        = hit_q;
    hit_idx_d    = hit_idx_q;
    ctx_d        = ctx_q;
    stm_d        = stm_q;
    done_d       = 1'b0;
    res_d        = res_q;

    if (ring_o.shift) begin
      idx_d = (idx_q == LAST) ? '0 : idx_q + IW'(1);
    end

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          ctx_d   = ctx_i;
          stm_d   = stm_i;
          cnt_d   = '0;
          hit_d   = 1'b0;
          sweep_d = 1'b0;
        end
      end
      ST_SEARCH: begin
        cnt_d = cnt_q + IW'(1);
        if (match && !hit_q) begin
          ring_o.wrap.used = 1'b1;
          hit_d            = 1'b1;
          hit_idx_d        = idx_q;
        end
        if (search_last && (hit_q || match)) begin
          done_d        = 1'b1;
          res_d.slot    = SLOT_W'(hit_q ? hit_idx_q : idx_q);
          res_d.hit     = 1'b1;
          res_d.evicted = 1'b0;
          res_d.ev_ctx  = '0;
          res_d.ev_stm  = '0;
        end
      end
      ST_PLACE: begin
        if (place_now) begin
          ring_o.wrap.ctx  = ctx_q;
          ring_o.wrap.stm  = stm_q;
          ring_o.wrap.used = 1'b1;
          done_d           = 1'b1;
          res_d.slot       = SLOT_W'(idx_q);
          res_d.hit        = 1'b0;
          res_d.evicted    = full;
          res_d.ev_ctx     = full ? head_i.ctx : '0;
          res_d.ev_stm     = full ? head_i.stm : '0;
          if (full) begin
            hand_d = idx_q;
          end else begin
            fill_d = fill_q + FW'(1);
          end
        end else if (full && sweep_on) begin
          // second chance: clear the bit and keep sweeping, the hand moves only on placement
          ring_o.wrap.used = 1'b0;
          sweep_d          = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      cnt_q   <= '0;
      fill_q  <= '0;
      hand_q  <= '0;
      sweep_q <= 1'b0;
      hit_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
      fill_q  <= fill_d;
      hand_q  <= hand_d;
      sweep_q <= sweep_d;
      hit_q   <= hit_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_idx_q <= hit_idx_d;
    ctx_q     <= ctx_d;
    stm_q     <= stm_d;
    res_q     <= res_d;
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire

[rtl/core/clock_replacement_key_cache_core.sv]
// fully associative key cache with clock replacement built on a rotating cell ring
// a hit returns done_o after one full ring revolution for the search; a miss
//   adds rotation to the free slot or to the hand and a sweep of up to
//   ENTRIES+1 cells
// throughput: one request at a time, start is taken again in the done_o cycle
// reset: async active low, clears fill count, clock hand, reference bits
// results are a one-cycle strobe on done_o, the receiver cannot stall
`default_nettype none

module clock_replacement_key_cache_core
  import crkc_pkg::*;
#(
  parameter int unsigned ENTRIES = ENTRIES_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [CTX_W-1:0]   context_tag_i,
  input  wire logic [STM_W-1:0]   statement_tag_i,
  output logic                    done_o,
  output logic [SLOT_W-1:0]       slot_o,
  output logic                    hit_o,
  output logic                    evicted_o,
  output logic [CTX_W-1:0]        evicted_context_o,
  output logic [STM_W-1:0]        evicted_statement_o
);

  // ring of cells: cell i loads from cell i+1, the last cell loads the
  // (possibly rewritten) entry leaving cell 0, so the slots rotate past
  // the single compare point at cell 0
  entry_t    cell_out [ENTRIES];
  entry_t    cell_in  [ENTRIES];
  ring_ctl_t ring_ctl;
  result_t   res;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_ring
    if (i == ENTRIES - 1) begin : g_tail
      assign cell_in[i] = ring_ctl.wrap;
    end else begin : g_link
      assign cell_in[i] = cell_out[i+1];
    end

    crkc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (ring_ctl.shift),
      .entry_i (cell_in[i]),
      .entry_o (cell_out[i])
    );
  end

  // sequencer: tracks which slot sits in cell 0, fill count and clock hand
  crkc_ctrl #(
    .ENTRIES (ENTRIES)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .ctx_i   (context_tag_i),
    .stm_i   (statement_tag_i),
    .head_i  (cell_out[0]),
    .ring_o  (ring_ctl),
    .done_o  (done_o),
    .res_o   (res)
  );

  assign slot_o              = res.slot;
  assign hit_o               = res.hit;
  assign evicted_o           = res.evicted;
  assign evicted_context_o   = res.ev_ctx;
  assign evicted_statement_o = res.ev_stm;

  // a hit never evicts
  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(hit_o && evicted_o))
    else $error("hit reported together with eviction");

  // eviction key fields are zero unless an entry was replaced
  a_evict_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !evicted_o) |-> (evicted_context_o == '0 && evicted_statement_o == '0))
    else $error("eviction key nonzero without eviction");

  // an accepted request keeps the core busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("request accepted but core not busy");

  // the result strobe lasts one cycle and arrives only after work
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result without a request in progress");

endmodule

`default_nettype wire

[sim/clock_replacement_key_cache_core_test.sv]
// self-checking testbench for the clock replacement key cache core
`timescale 1ns / 1ps

module clock_replacement_key_cache_core_test;
  import crkc_pkg::*;

  localparam int unsigned ENTRIES    = ENTRIES_DEF;
  // slowest request: a search pass, then rotation to the hand and a full sweep to place
  localparam int unsigned WORST_LAT  = 3 * ENTRIES + 1;
  localparam int unsigned POOL_SIZE  = 256;
  localparam int unsigned PHASE_REQS = 150;
  localparam longint      CYCLE_CAP  = 1000000;

  // ---------------------------------------------------------------------------
  // clock, reset and block ports
  // ---------------------------------------------------------------------------
  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  logic [CTX_W-1:0] context_tag_i;
  logic [STM_W-1:0] statement_tag_i;
  logic              done_o;
  logic [SLOT_W-1:0] slot_o;
  logic              hit_o;
  logic              evicted_o;
  logic [CTX_W-1:0]  evicted_context_o;
  logic [STM_W-1:0]  evicted_statement_o;

  clock_replacement_key_cache_core #(
    .ENTRIES (ENTRIES)
  ) dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start               (start),
    .busy                (busy),
    .context_tag_i       (context_tag_i),
    .statement_tag_i     (statement_tag_i),
    .done_o              (done_o),
    .slot_o              (slot_o),
    .hit_o               (hit_o),
    .evicted_o           (evicted_o),
    .evicted_context_o   (evicted_context_o),
    .evicted_statement_o (evicted_statement_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // cache predictor: own copy of keys, reference bits, fill count and hand
  // ---------------------------------------------------------------------------
  logic [CTX_W-1:0]  cache_ctx [ENTRIES];
  logic [STM_W-1:0]  cache_stm [ENTRIES];
  bit                ref_seen  [ENTRIES];
  int unsigned       filled;
  int unsigned       hand;

  // lookups accepted by the block whose results have not come back yet
  result_t           pending_lookups [$];

  int unsigned       mismatches;
  longint            cycle_count;

  // directed rows; typed rows carry a result read straight off the spec
  typedef struct {
    logic [CTX_W-1:0] ctx;
    logic [STM_W-1:0] stm;
    bit               typed;
    result_t          want;
  } stim_row_t;

  stim_row_t         dir_rows [$];

  // working-set keys for the random phases
  logic [CTX_W-1:0]  pool_ctx [POOL_SIZE];
  logic [STM_W-1:0]  pool_stm [POOL_SIZE];

  // sender pacing: burst means back-to-back requests with no gaps
  bit                burst;
  int unsigned       issued;

  // search the valid prefix, then fill or run the second-chance sweep
  function automatic result_t predict_lookup(input logic [CTX_W-1:0] ctx,
                                             input logic [STM_W-1:0] stm);
    result_t     r;
    int unsigned i;
    int unsigned target;
    bit          found;
    r     = '0;
    found = 1'b0;
    for (i = 0; i < filled; i++) begin
      if (!found && cache_ctx[i] == ctx && cache_stm[i] == stm) begin
        found      = 1'b1;
        ref_seen[i] = 1'b1;
        r.slot     = SLOT_W'(i);
        r.hit      = 1'b1;
      end
    end
    if (!found) begin
      if (filled < ENTRIES) begin
        // table not full yet: next free slot in the prefix
        target = filled;
        filled = filled + 1;
      end else begin
        // clear reference bits from the hand until a clear one shows up
        while (ref_seen[hand]) begin
          ref_seen[hand] = 1'b0;
          hand = (hand + 1) % ENTRIES;
        end
        target    = hand;
        r.evicted = 1'b1;
        r.ev_ctx  = cache_ctx[target];
        r.ev_stm  = cache_stm[target];
      end
      cache_ctx[target] = ctx;
      cache_stm[target] = stm;
      ref_seen[target]  = 1'b1;
      r.slot            = SLOT_W'(target);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // result checker: every done_o strobe pops the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_check
    result_t want;
    bit      bad;
    if (rst_ni && done_o === 1'b1) begin
      if (pending_lookups.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: result with no request outstanding: slot %0d hit %0b",
                   $realtime, slot_o, hit_o);
        mismatches = mismatches + 1;
      end else begin
        want = pending_lookups.pop_front();
        bad  = (slot_o !== want.slot) || (hit_o !== want.hit) ||
               (evicted_o !== want.evicted) ||
               (evicted_context_o !== want.ev_ctx) ||
               (evicted_statement_o !== want.ev_stm);
        if (bad) begin
          if (mismatches < 10) begin
            $display("%0t: result mismatch", $realtime);
            $display("  expected slot %0d hit %0b evicted %0b ctx %h stm %h",
                     want.slot, want.hit, want.evicted, want.ev_ctx, want.ev_stm);
            $display("  actual   slot %0d hit %0b evicted %0b ctx %h stm %h",
                     slot_o, hit_o, evicted_o, evicted_context_o,
                     evicted_statement_o);
          end
          mismatches = mismatches + 1;
        end
      end
    end
  end

  // watchdog, sized for every request at worst latency and longest gap
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_CAP) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------

  // hand one request to the block, predict it on acceptance, then idle a while
  task automatic issue_lookup(input logic [CTX_W-1:0] ctx,
                              input logic [STM_W-1:0] stm,
                              input bit typed, input result_t want);
    result_t     r;
    int unsigned gap;
    if (issued % 25 == 0)
      burst = ($urandom_range(0, 3) == 0);
    gap = burst ? 0 : $urandom_range(0, 18);
    @(negedge clk_i);
    start           <= 1'b1;
    context_tag_i   <= ctx;
    statement_tag_i <= stm;
    // accepted at the first rising edge with busy low
    do @(posedge clk_i); while (busy !== 1'b0);
    r = predict_lookup(ctx, stm);
    pending_lookups.push_back(typed ? want : r);
    issued = issued + 1;
    if (gap > 0) begin
      // idle cycles carry junk on the key ports, the block must ignore it
      @(negedge clk_i);
      start           <= 1'b0;
      context_tag_i   <= CTX_W'($urandom);
      statement_tag_i <= $urandom;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // hold off until every outstanding request has returned
  task automatic drain_pending;
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk_i);
  endtask

  task automatic add_row(input logic [CTX_W-1:0] ctx, input logic [STM_W-1:0] stm,
                         input bit typed, input int unsigned slot, input bit hit);
    stim_row_t row;
    row.ctx          = ctx;
    row.stm          = stm;
    row.typed        = typed;
    row.want         = '0;
    row.want.slot    = SLOT_W'(slot);
    row.want.hit     = hit;
    dir_rows.push_back(row);
  endtask

  initial begin : stimulus
    logic [CTX_W-1:0] ctx_base [4];
    logic [STM_W-1:0] stm_base [4];
    logic [CTX_W-1:0] ctx;
    logic [STM_W-1:0] stm;
    int unsigned      phase_keys [4];
    int unsigned      window;
    int unsigned      pick;
    int unsigned      flip;
    int unsigned      p;
    int unsigned      n;
    int unsigned      i;

    // every input known from time zero, reset held low before the first request
    rst_ni          = 1'b0;
    start           = 1'b0;
    context_tag_i   = '0;
    statement_tag_i = '0;
    cycle_count     = 0;
    mismatches      = 0;
    issued          = 0;
    burst           = 1'b0;
    filled          = 0;
    hand            = 0;
    for (i = 0; i < ENTRIES; i++) begin
      cache_ctx[i] = '0;
      cache_stm[i] = '0;
      ref_seen[i]  = 1'b0;
    end

    // pool keys often share a context or a statement tag, so half matches
    // on one side of the key exercise the comparator
    for (i = 0; i < 4; i++) begin
      ctx_base[i] = CTX_W'($urandom);
      stm_base[i] = $urandom;
    end
    for (i = 0; i < POOL_SIZE; i++) begin
      pool_ctx[i] = $urandom_range(0, 1) ? ctx_base[$urandom_range(0, 3)]
                                         : CTX_W'($urandom);
      pool_stm[i] = $urandom_range(0, 1) ? stm_base[$urandom_range(0, 3)] : $urandom;
    end

    // directed rows on an empty table: zero key, all-ones key, single-bit
    // neighbours, hits on earlier keys
    add_row(16'h0000, 32'h0000_0000, 1'b1, 0,  1'b0);
    add_row(16'hFFFF, 32'hFFFF_FFFF, 1'b1, 1,  1'b0);
    add_row(16'h0000, 32'h0000_0000, 1'b1, 0,  1'b1);
    add_row(16'hFFFF, 32'h0000_0000, 1'b1, 2,  1'b0);
    add_row(16'h0000, 32'hFFFF_FFFF, 1'b1, 3,  1'b0);
    add_row(16'hFFFF, 32'hFFFF_FFFF, 1'b1, 1,  1'b1);
    add_row(16'h0000, 32'h0000_0001, 1'b1, 4,  1'b0);
    add_row(16'h0001, 32'h0000_0000, 1'b1, 5,  1'b0);
    add_row(16'h8000, 32'h8000_0000, 1'b1, 6,  1'b0);
    add_row(16'h0000, 32'h0000_0000, 1'b1, 0,  1'b1);
    add_row(16'h0000, 32'h0000_0001, 1'b1, 4,  1'b1);
    add_row(16'hFFFE, 32'hFFFF_FFFE, 1'b1, 7,  1'b0);
    add_row(16'h5555, 32'hAAAA_AAAA, 1'b1, 8,  1'b0);
    add_row(16'hAAAA, 32'h5555_5555, 1'b1, 9,  1'b0);
    add_row(16'h5555, 32'hAAAA_AAAA, 1'b1, 8,  1'b1);
    add_row(16'h0001, 32'hFFFF_FFFF, 1'b1, 10, 1'b0);
    add_row(16'hFFFF, 32'hFFFF_FFFF, 1'b1, 1,  1'b1);
    add_row(16'h8000, 32'h8000_0000, 1'b1, 6,  1'b1);
    add_row(16'h1234, 32'h89AB_CDEF, 1'b0, 0,  1'b0);
    add_row(16'h1234, 32'h89AB_CDEE, 1'b0, 0,  1'b0);
    add_row(16'h1234, 32'h89AB_CDEF, 1'b0, 0,  1'b0);
    add_row(16'hAAAA, 32'h5555_5555, 1'b0, 0,  1'b0);

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[k])
      issue_lookup(dir_rows[k].ctx, dir_rows[k].stm, dir_rows[k].typed, dir_rows[k].want);

    // fill the rest of the table with fresh keys; every slot then has its
    // reference bit set, so the first eviction sweeps a full turn
    while (filled < ENTRIES)
      issue_lookup(CTX_W'($urandom), $urandom, 1'b0, '0);
    for (i = 0; i < 3; i++)
      issue_lookup(CTX_W'($urandom), $urandom, 1'b0, '0);
    // a hit on the zero key if it survived, then more pressure on the hand
    issue_lookup(16'h0000, 32'h0000_0000, 1'b0, '0);
    issue_lookup(16'hFFFF, 32'hFFFF_FFFF, 1'b0, '0);
    drain_pending();

    // random phases: working sets below, just above, well above and equal
    // to capacity, so hits, short sweeps and thrashing all show up
    phase_keys[0] = 48;
    phase_keys[1] = 72;
    phase_keys[2] = 160;
    phase_keys[3] = ENTRIES;
    for (p = 0; p < 4; p++) begin
      window = $urandom_range(0, POOL_SIZE - phase_keys[p]);
      for (n = 0; n < PHASE_REQS; n++) begin
        pick = window + $urandom_range(0, phase_keys[p] - 1);
        ctx  = pool_ctx[pick];
        stm  = pool_stm[pick];
        if ($urandom_range(0, 99) < 12) begin
          // noise: a key off by one bit, or a fully random one
          flip = $urandom_range(0, CTX_W + STM_W - 1);
          if ($urandom_range(0, 1)) begin
            ctx = CTX_W'($urandom);
            stm = $urandom;
          end else if (flip < CTX_W) begin
            ctx[flip] = ~ctx[flip];
          end else begin
            stm[flip - CTX_W] = ~stm[flip - CTX_W];
          end
        end
        issue_lookup(ctx, stm, 1'b0, '0);
      end
      // sender waits for every outstanding request between phases
      drain_pending();
    end

    // let any stray strobe surface before the verdict
    repeat (WORST_LAT + 8) @(posedge clk_i);
    if (mismatches == 0 && pending_lookups.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

[filelist.f]
rtl/core/crkc_pkg.sv
rtl/core/crkc_cell.sv
rtl/core/crkc_ctrl.sv
rtl/core/clock_replacement_key_cache_core.sv
sim/clock_replacement_key_cache_core_test.sv
